FILE: src/drt_pkg.sv
// Shared types, constants and trig tables for the dead-reckoning route tracker.
// Used by drt_ctrl, drt_dp and dead_reckoning_route_tracker.
`timescale 1ns / 1ps

package drt_pkg;

	// Coordinate and field widths
	localparam int COORD_W   = 24;
	localparam int OUT_W     = 24;
	localparam int CFG_W     = 16;
	localparam int IDX_W     = 2;
	localparam int DUR_W     = 16;
	localparam int CODE_W    = 2;
	localparam int HEAD_W    = 4;
	localparam int HEADINGS  = 12;
	localparam int FRAC_BITS = 24;

	// Datapath widths: len is Q8, trig is signed Q16
	localparam int LEN_W  = DUR_W + CFG_W;
	localparam int TRIG_W = 18;
	localparam int DISP_W = LEN_W + 1 + TRIG_W;
	localparam int SUM_W  = ((COORD_W + FRAC_BITS > DISP_W) ? (COORD_W + FRAC_BITS) : DISP_W) + 1;
	localparam int RND_W  = SUM_W - FRAC_BITS;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_START_X   = 2'd0;
	localparam logic [IDX_W-1:0] REG_START_Y   = 2'd1;
	localparam logic [IDX_W-1:0] REG_STEP_GAIN = 2'd2;

	// Request types and direction codes
	localparam logic REQ_TRAVEL = 1'b0;
	localparam logic REQ_TURN   = 1'b1;

	localparam logic [CODE_W-1:0] DIR_LEFT_A = 2'd0;
	localparam logic [CODE_W-1:0] DIR_RIGHT  = 2'd1;
	localparam logic [CODE_W-1:0] DIR_LEFT_B = 2'd2;

	localparam logic [CFG_W-1:0] GAIN_RESET = 16'd256;

	// Commands from the sequencer to the datapath
	typedef struct packed {
		logic load;   // capture travel operands
		logic turn;   // apply a direction event
		logic mul1;   // len = duration * gain
		logic mul2;   // displacements = len * trig
		logic sum;    // add scaled coordinate
		logic fin;    // round, clamp, update endpoint, load output
	} drt_cmd_t;

	// Cosine in signed Q16 per 30-degree step
	function automatic logic signed [TRIG_W-1:0] cos_q16(input logic [HEAD_W-1:0] h);
		logic signed [TRIG_W-1:0] v;
		case (h)
			4'd0:    v = 18'sd65536;
			4'd1:    v = 18'sd56755;
			4'd2:    v = 18'sd32768;
			4'd3:    v = 18'sd0;
			4'd4:    v = -18'sd32768;
			4'd5:    v = -18'sd56755;
			4'd6:    v = -18'sd65536;
			4'd7:    v = -18'sd56755;
			4'd8:    v = -18'sd32768;
			4'd9:    v = 18'sd0;
			4'd10:   v = 18'sd32768;
			4'd11:   v = 18'sd56755;
			default: v = 18'sd0;
		endcase
		return v;
	endfunction

	// Sine in signed Q16 per 30-degree step
	function automatic logic signed [TRIG_W-1:0] sin_q16(input logic [HEAD_W-1:0] h);
		logic signed [TRIG_W-1:0] v;
		case (h)
			4'd0:    v = 18'sd0;
			4'd1:    v = 18'sd32768;
			4'd2:    v = 18'sd56755;
			4'd3:    v = 18'sd65536;
			4'd4:    v = 18'sd56755;
			4'd5:    v = 18'sd32768;
			4'd6:    v = 18'sd0;
			4'd7:    v = -18'sd32768;
			4'd8:    v = -18'sd56755;
			4'd9:    v = -18'sd65536;
			4'd10:   v = -18'sd56755;
			4'd11:   v = -18'sd32768;
			default: v = 18'sd0;
		endcase
		return v;
	endfunction

endpackage

FILE: src/drt_ctrl.sv
// Sequencer for the route tracker: accepts items, steps the datapath, owns out_valid.
// Depends on drt_pkg.
`timescale 1ns / 1ps

module drt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	output logic              out_valid,
	input  logic              out_ready,
	output drt_pkg::drt_cmd_t cmd
);
	import drt_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL1 = 3'd1;
	localparam logic [2:0] S_MUL2 = 3'd2;
	localparam logic [2:0] S_SUM  = 3'd3;
	localparam logic [2:0] S_RND  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       accept;
	logic       can_fin;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign can_fin   = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_type == REQ_TURN) begin
						cmd.turn = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d  = S_MUL1;
					end
				end
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_RND;
			end
			S_RND: begin
				// hold until the output register is free
				if (can_fin) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A finish never overwrites a result that has not been taken
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> (!out_valid_q || out_ready))
		else $error("finish while output held");

	// Multiply steps run back to back
	a_mul_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL1) |=> (state_q == S_MUL2))
		else $error("MUL1 not followed by MUL2");

	// A travel item yields exactly one result; the input stays closed through its multiply and sum steps
	a_travel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("input taken while travel item in flight");

endmodule

FILE: src/drt_dp.sv
// Datapath for the route tracker: heading, endpoint, multiply, round and clamp.
// Depends on drt_pkg; stepped by drt_ctrl commands.
`timescale 1ns / 1ps

module drt_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  drt_pkg::drt_cmd_t                   cmd,
	input  logic                                cfg_wen,
	input  logic [drt_pkg::IDX_W-1:0]           cfg_index,
	input  logic [drt_pkg::CFG_W-1:0]           cfg_wdata,
	input  logic [drt_pkg::DUR_W-1:0]           duration,
	input  logic [drt_pkg::CODE_W-1:0]          direction_code,
	output logic signed [drt_pkg::OUT_W-1:0]    seg_x0,
	output logic signed [drt_pkg::OUT_W-1:0]    seg_y0,
	output logic signed [drt_pkg::OUT_W-1:0]    seg_x1,
	output logic signed [drt_pkg::OUT_W-1:0]    seg_y1,
	output logic [drt_pkg::HEAD_W-1:0]          heading_step,
	output logic                                saturated
);
	import drt_pkg::*;

	localparam logic signed [RND_W-1:0] R_MAX =
		RND_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
	localparam logic signed [RND_W-1:0] R_MIN = RND_W'(-(64'sd1 <<< (COORD_W - 1)));
	localparam logic signed [SUM_W-1:0] HALF  = SUM_W'(64'sd1 <<< (FRAC_BITS - 1));
	localparam logic signed [COORD_W:0] S_MAX =
		(COORD_W + 1)'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);

	logic [CFG_W-1:0]          gain_q;
	logic signed [COORD_W-1:0] end_x_q;
	logic signed [COORD_W-1:0] end_y_q;
	logic [HEAD_W-1:0]         heading_q;
	logic [DUR_W-1:0]          dur_q;
	logic [LEN_W-1:0]          len_s1;
	logic signed [DISP_W-1:0]  dx_s2;
	logic signed [DISP_W-1:0]  dy_s2;
	logic signed [SUM_W-1:0]   sx_s3;
	logic signed [SUM_W-1:0]   sy_s3;
	logic signed [RND_W-1:0]   rx;
	logic signed [RND_W-1:0]   ry;
	logic signed [COORD_W-1:0] nx;
	logic signed [COORD_W-1:0] ny;
	logic                      sat_x;
	logic                      sat_y;
	logic signed [COORD_W-1:0] cfg_coord;

	// Clamp a start value to the coordinate range
	always_comb begin
		if ($signed({1'b0, (COORD_W)'(cfg_wdata)}) > S_MAX && COORD_W <= CFG_W) begin
			cfg_coord = COORD_W'(S_MAX);
		end else begin
			cfg_coord = COORD_W'({1'b0, cfg_wdata});
		end
	end

	// Round half away from zero, then clamp
	always_comb begin
		rx    = RND_W'((sx_s3 + HALF - SUM_W'(sx_s3[SUM_W-1])) >>> FRAC_BITS);
		ry    = RND_W'((sy_s3 + HALF - SUM_W'(sy_s3[SUM_W-1])) >>> FRAC_BITS);
		sat_x = 1'b0;
		sat_y = 1'b0;
		if (rx > R_MAX) begin
			nx    = COORD_W'(R_MAX);
			sat_x = 1'b1;
		end else if (rx < R_MIN) begin
			nx    = COORD_W'(R_MIN);
			sat_x = 1'b1;
		end else begin
			nx = COORD_W'(rx);
		end
		if (ry > R_MAX) begin
			ny    = COORD_W'(R_MAX);
			sat_y = 1'b1;
		end else if (ry < R_MIN) begin
			ny    = COORD_W'(R_MIN);
			sat_y = 1'b1;
		end else begin
			ny = COORD_W'(ry);
		end
	end

	// Architectural state: gain, endpoint, heading
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q    <= GAIN_RESET;
			end_x_q   <= '0;
			end_y_q   <= '0;
			heading_q <= '0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_START_X:   end_x_q <= cfg_coord;
					REG_START_Y:   end_y_q <= cfg_coord;
					REG_STEP_GAIN: gain_q  <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.turn) begin
				if (direction_code inside {DIR_LEFT_A, DIR_LEFT_B}) begin
					heading_q <= (heading_q == HEAD_W'(HEADINGS - 1)) ? '0 : heading_q + 1'b1;
				end else if (direction_code == DIR_RIGHT) begin
					heading_q <= (heading_q == '0) ? HEAD_W'(HEADINGS - 1) : heading_q - 1'b1;
				end
			end
			if (cmd.fin) begin
				end_x_q <= nx;
				end_y_q <= ny;
			end
		end
	end

	// Operand capture, multiply and sum stages
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dur_q <= duration;
		end
		if (cmd.mul1) begin
			len_s1 <= LEN_W'(dur_q) * LEN_W'(gain_q);
		end
		if (cmd.mul2) begin
			dx_s2 <= DISP_W'($signed({1'b0, len_s1}) * cos_q16(heading_q));
			dy_s2 <= DISP_W'($signed({1'b0, len_s1}) * sin_q16(heading_q));
		end
		if (cmd.sum) begin
			sx_s3 <= (SUM_W'(end_x_q) <<< FRAC_BITS) + SUM_W'(dx_s2);
			sy_s3 <= (SUM_W'(end_y_q) <<< FRAC_BITS) + SUM_W'(dy_s2);
		end
	end

	// Output register: load the segment
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			seg_x0       <= OUT_W'(end_x_q);
			seg_y0       <= OUT_W'(end_y_q);
			seg_x1       <= OUT_W'(nx);
			seg_y1       <= OUT_W'(ny);
			heading_step <= heading_q;
			saturated    <= sat_x | sat_y;
		end
	end

	// Heading stays in range
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		heading_q < HEAD_W'(HEADINGS))
		else $error("heading out of range");

	// Heading moves only on a direction event
	a_head_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.turn |=> $stable(heading_q))
		else $error("heading changed without turn");

	// Endpoint moves only on a register write or a finished travel item
	a_end_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!cfg_wen && !cmd.fin) |=> ($stable(end_x_q) && $stable(end_y_q)))
		else $error("endpoint changed without write or finish");

endmodule

FILE: src/dead_reckoning_route_tracker.sv
// A travel item presents its segment after two multiply steps, sum and round; round waits
// while the result register is held. A direction event gives no result.
// The sequencer takes one travel item at a time, walking it through the shared
// multiply/round datapath; the result register frees the input while it waits.
// Reset (arst_n low): start point 0, gain 256 (1.0), heading 0, no result pending.
// Top level of the route tracker; instantiates drt_ctrl and drt_dp, uses drt_pkg.
`timescale 1ns / 1ps

module dead_reckoning_route_tracker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [drt_pkg::IDX_W-1:0]           cfg_index,
	input  logic [drt_pkg::CFG_W-1:0]           cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                req_type,
	input  logic [drt_pkg::DUR_W-1:0]           duration,
	input  logic [drt_pkg::CODE_W-1:0]          direction_code,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [drt_pkg::OUT_W-1:0]    seg_x0,
	output logic signed [drt_pkg::OUT_W-1:0]    seg_y0,
	output logic signed [drt_pkg::OUT_W-1:0]    seg_x1,
	output logic signed [drt_pkg::OUT_W-1:0]    seg_y1,
	output logic [drt_pkg::HEAD_W-1:0]          heading_step,
	output logic                                saturated
);
	import drt_pkg::*;

	drt_cmd_t cmd;

	// Sequencer
	drt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Datapath
	drt_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_wen        (cfg_wen),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.duration       (duration),
		.direction_code (direction_code),
		.seg_x0         (seg_x0),
		.seg_y0         (seg_y0),
		.seg_x1         (seg_x1),
		.seg_y1         (seg_y1),
		.heading_step   (heading_step),
		.saturated      (saturated)
	);

endmodule

FILE: verif/dead_reckoning_route_tracker_test.sv
// Self-checking testbench for dead_reckoning_route_tracker: random travel and turn items,
// random stalls on both channels, and segments checked against a predictor held in a scoreboard.
// Depends on drt_pkg and dead_reckoning_route_tracker.
`timescale 1ns / 1ps

module dead_reckoning_route_tracker_test;

	import drt_pkg::*;

	localparam logic [IDX_W-1:0]  REG_UNUSED  = 2'd3;
	localparam logic [CODE_W-1:0] DIR_HOLD    = 2'd3;
	localparam longint COORD_MAX   = (longint'(1) <<< (COORD_W - 1)) - 1;
	localparam longint COORD_MIN   = -(longint'(1) <<< (COORD_W - 1));
	localparam int     HOLD_CYCLES = 300;
	localparam int     STALL_LIMIT = 2000;
	localparam int     MAX_REPORTS = 200;

	typedef struct {
		logic signed [OUT_W-1:0] x0;
		logic signed [OUT_W-1:0] y0;
		logic signed [OUT_W-1:0] x1;
		logic signed [OUT_W-1:0] y1;
		logic [HEAD_W-1:0]       heading;
		logic                    sat;
	} segment_t;

	// Track position and heading, queue the segments each travel item should produce
	class route_scoreboard;
		segment_t          segments_due[$];
		int                errors;
		int                reports;
		longint            pos_x;
		longint            pos_y;
		logic [CFG_W-1:0]  gain;
		int                heading;

		function new();
			errors  = 0;
			reports = 0;
			pos_x   = 0;
			pos_y   = 0;
			gain    = GAIN_RESET;
			heading = 0;
		endfunction

		function int pending();
			return segments_due.size();
		endfunction

		// Start point writes also move the current endpoint
		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
			case (idx)
				REG_START_X:   pos_x = value;
				REG_START_Y:   pos_y = value;
				REG_STEP_GAIN: gain = value;
				default: ;
			endcase
		endfunction

		// Cosine of step*30 degrees in Q16, folded onto the first quadrant
		function int cosine_of_step(int step);
			int k;
			int q;
			int mag;
			k = step % HEADINGS;
			if (k > 6)
				k = HEADINGS - k;
			q = (k > 3) ? 6 - k : k;
			case (q)
				0:       mag = 65536;
				1:       mag = 56755;
				2:       mag = 32768;
				default: mag = 0;
			endcase
			return (k > 3) ? -mag : mag;
		endfunction

		// Add len*trig to a coordinate in 2^-24 units, round half away from zero, clamp
		function longint move_axis(longint cur, longint len, int trig, inout bit sat);
			longint total;
			longint half;
			longint r;
			half  = longint'(1) <<< (FRAC_BITS - 1);
			total = (cur <<< FRAC_BITS) + len * trig;
			if (total >= 0)
				r = (total + half) >>> FRAC_BITS;
			else
				r = -((-total + half) >>> FRAC_BITS);
			if (r > COORD_MAX) begin
				sat = 1'b1;
				r = COORD_MAX;
			end else if (r < COORD_MIN) begin
				sat = 1'b1;
				r = COORD_MIN;
			end
			return r;
		endfunction

		function void note_item(logic rt, logic [DUR_W-1:0] dur, logic [CODE_W-1:0] code);
			segment_t seg;
			longint   len;
			longint   nx;
			longint   ny;
			bit       sat;
			// Turns only rotate the heading, wrapping modulo twelve
			if (rt == REQ_TURN) begin
				if (code == DIR_LEFT_A || code == DIR_LEFT_B)
					heading = (heading + 1) % HEADINGS;
				else if (code == DIR_RIGHT)
					heading = (heading + HEADINGS - 1) % HEADINGS;
				return;
			end
			len = dur;
			len = len * gain;
			sat = 1'b0;
			nx = move_axis(pos_x, len, cosine_of_step(heading), sat);
			ny = move_axis(pos_y, len, cosine_of_step(heading + 9), sat);
			seg.x0      = pos_x[OUT_W-1:0];
			seg.y0      = pos_y[OUT_W-1:0];
			seg.x1      = nx[OUT_W-1:0];
			seg.y1      = ny[OUT_W-1:0];
			seg.heading = heading[HEAD_W-1:0];
			seg.sat     = sat;
			segments_due.push_back(seg);
			pos_x = nx;
			pos_y = ny;
		endfunction

		function void compare_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
			if (want !== got) begin
				errors++;
				// cap the log on a badly broken block; the count still goes up
				if (reports < MAX_REPORTS) begin
					reports++;
					$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
						$signed(want), $signed(got));
				end
			end
		endfunction

		function void check_segment(logic [OUT_W-1:0] x0, logic [OUT_W-1:0] y0,
				logic [OUT_W-1:0] x1, logic [OUT_W-1:0] y1,
				logic [HEAD_W-1:0] h, logic sat);
			segment_t want;
			if (segments_due.size() == 0) begin
				errors++;
				$display("%0t: segment with no travel item waiting, expected none, actual %0d %0d %0d %0d",
					$time, $signed(x0), $signed(y0), $signed(x1), $signed(y1));
				return;
			end
			want = segments_due.pop_front();
			compare_field("seg_x0", want.x0, x0);
			compare_field("seg_y0", want.y0, y0);
			compare_field("seg_x1", want.x1, x1);
			compare_field("seg_y1", want.y1, y1);
			compare_field("heading_step", OUT_W'(want.heading), OUT_W'(h));
			compare_field("saturated", OUT_W'(want.sat), OUT_W'(sat));
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_wen = 1'b0;
	logic [IDX_W-1:0]        cfg_index = '0;
	logic [CFG_W-1:0]        cfg_wdata = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic                    req_type = 1'b0;
	logic [DUR_W-1:0]        duration = '0;
	logic [CODE_W-1:0]       direction_code = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [OUT_W-1:0] seg_x0;
	logic signed [OUT_W-1:0] seg_y0;
	logic signed [OUT_W-1:0] seg_x1;
	logic signed [OUT_W-1:0] seg_y1;
	logic [HEAD_W-1:0]       heading_step;
	logic                    saturated;

	route_scoreboard scoreboard;
	int              send_gap_max = 18;
	int              recv_gap_max = 18;
	bit              hold_request = 1'b0;

	dead_reckoning_route_tracker dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.duration       (duration),
		.direction_code (direction_code),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.seg_x0         (seg_x0),
		.seg_y0         (seg_y0),
		.seg_x1         (seg_x1),
		.seg_y1         (seg_y1),
		.heading_step   (heading_step),
		.saturated      (saturated)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one item after a random gap and hold it until accepted; call at a falling edge
	task automatic send_item(logic rt, logic [DUR_W-1:0] dur, logic [CODE_W-1:0] code);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid       = 1'b1;
		req_type       = rt;
		duration       = dur;
		direction_code = code;
		do @(posedge clk); while (!in_ready);
		scoreboard.note_item(rt, dur, code);
		@(negedge clk);
	endtask

	task automatic travel(logic [DUR_W-1:0] dur);
		send_item(REQ_TRAVEL, dur, CODE_W'($urandom_range(0, 3)));
	endtask

	task automatic turn(logic [CODE_W-1:0] code);
		send_item(REQ_TURN, DUR_W'($urandom_range(0, 65535)), code);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		cfg_wen   = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_wen = 1'b0;
		scoreboard.write_reg(idx, value);
	endtask

	// Drain every segment, let a pending turn settle, then load a new setting
	task automatic apply_setting(logic [CFG_W-1:0] sx, logic [CFG_W-1:0] sy,
			logic [CFG_W-1:0] g);
		in_valid = 1'b0;
		while (scoreboard.pending() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		write_reg(REG_STEP_GAIN, g);
		write_reg(REG_START_X, sx);
		write_reg(REG_START_Y, sy);
		write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 65535)));
	endtask

	// Short and mid-range moves most often, some full-range and some at the extremes
	function automatic logic [DUR_W-1:0] pick_duration();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
		else if (pick < 5)
			return DUR_W'($urandom_range(0, 63));
		else if (pick < 8)
			return DUR_W'($urandom_range(0, 4095));
		return DUR_W'($urandom_range(0, 65535));
	endfunction

	task automatic random_items(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 6)
				travel(pick_duration());
			else
				turn(CODE_W'($urandom_range(0, 3)));
		end
	endtask

	// Receive side: random stall per segment, one long hold when asked
	initial begin
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = $urandom_range(0, recv_gap_max);
			if (hold_request) begin
				hold_request = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			scoreboard.check_segment(seg_x0, seg_y0, seg_x1, seg_y1, heading_step, saturated);
			@(negedge clk);
		end
	end

	// Watchdog: end the run when neither channel moves for too long
	initial begin
		int idle;
		idle = 0;
		@(posedge arst_n);
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
		end
		$display("dead_reckoning_route_tracker verification failed");
		$finish;
	end

	initial begin
		logic [CFG_W-1:0] sx;
		logic [CFG_W-1:0] sy;
		logic [CFG_W-1:0] g;
		scoreboard = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed moves at reset defaults: zero and full durations, wraps, every heading axis
		travel(16'h0000);
		travel(16'h0001);
		travel(16'hFFFF);
		turn(DIR_RIGHT);
		travel(16'd100);
		turn(DIR_HOLD);
		travel(16'd7);
		turn(DIR_LEFT_A);
		turn(DIR_LEFT_B);
		travel(16'hFFFF);
		turn(DIR_LEFT_A);
		travel(16'd300);
		turn(DIR_LEFT_B);
		travel(16'hFFFF);
		repeat (3) turn(DIR_LEFT_A);
		travel(16'hFFFF);
		repeat (3) turn(DIR_LEFT_B);
		travel(16'hAAAA);

		// Random phases, each under its own start point, gain and idling pattern
		for (int p = 0; p < 8; p++) begin
			case (p)
				0:       begin sx = 16'd100;   sy = 16'd200;   g = 16'd256;   end
				1:       begin sx = 16'hFFFF;  sy = 16'hFFFF;  g = 16'hFFFF;  end
				2:       begin sx = 16'h0000;  sy = 16'h0000;  g = 16'h0000;  end
				3:       begin sx = CFG_W'($urandom_range(0, 65535));
					sy = CFG_W'($urandom_range(0, 65535)); g = 16'd1; end
				4:       begin sx = 16'h8000;  sy = 16'd12345; g = 16'hFFFF;  end
				5:       begin sx = CFG_W'($urandom_range(0, 65535));
					sy = CFG_W'($urandom_range(0, 65535));
					g = CFG_W'($urandom_range(0, 65535)); end
				6:       begin sx = 16'h0000;  sy = 16'hFFFF;  g = 16'd384;   end
				default: begin sx = CFG_W'($urandom_range(0, 65535));
					sy = CFG_W'($urandom_range(0, 65535));
					g = CFG_W'($urandom_range(0, 1023)); end
			endcase
			apply_setting(sx, sy, g);
			case (p % 3)
				0:       begin send_gap_max = 18; recv_gap_max = 18; end
				1:       begin send_gap_max = 0;  recv_gap_max = 0;  end
				default: begin send_gap_max = 0;  recv_gap_max = 18; end
			endcase
			// back-to-back items against a held receiver fill the block
			if (p == 4)
				hold_request = 1'b1;
			random_items(150);
		end

		in_valid = 1'b0;
		while (scoreboard.pending() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (scoreboard.errors == 0)
			$display("dead_reckoning_route_tracker verification clean");
		else
			$display("dead_reckoning_route_tracker verification failed");
		$finish;
	end

endmodule

FILE: dead_reckoning_route_tracker.f
src/drt_pkg.sv
src/drt_ctrl.sv
src/drt_dp.sv
src/dead_reckoning_route_tracker.sv
verif/dead_reckoning_route_tracker_test.sv
